@@ hdl/rsfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfc_pkg
// Shared payload types for the ray/sphere far clip block.
// ----------------------------------------------------------------------------
package rsfc_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned DirW    = 16;
  localparam int unsigned RadiusW = 24;
  localparam int unsigned AddrW   = 1;

  localparam logic [AddrW-1:0] RegRadius = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [DirW-1:0]   dir_x;
    logic signed [DirW-1:0]   dir_y;
    logic signed [DirW-1:0]   dir_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
  } ray_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } res_t;

endpackage

@@ hdl/rsfc_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfc_sqrt
// Pipelined restoring square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rsfc_sqrt #(
  parameter int unsigned InW = 48,
  parameter int unsigned SbW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [InW-1:0]       rad_i,
  input  logic [SbW-1:0]       sb_i,
  output logic                 valid_o,
  output logic [InW/2-1:0]     root_o,
  output logic [SbW-1:0]       sb_o
);

  localparam int unsigned N = InW / 2;

  logic [N:0]          v_q;
  logic [InW-1:0]      x_q   [N+1];
  logic [InW-1:0]      res_q [N+1];
  logic [SbW-1:0]      sb_q  [N+1];

  always_comb begin
    v_q[0]   = valid_i;
    x_q[0]   = rad_i;
    res_q[0] = '0;
    sb_q[0]  = sb_i;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam logic [InW-1:0] Bit = InW'(1) << (2 * (N - 1 - k));
    logic [InW-1:0] trial;
    logic [InW-1:0] x_d, res_d;
    logic           v_r;
    logic [InW-1:0] x_r, res_r;
    logic [SbW-1:0] sb_r;
    always_comb begin
      trial = res_q[k] + Bit;
      if (x_q[k] >= trial) begin
        x_d   = x_q[k] - trial;
        res_d = (res_q[k] >> 1) + Bit;
      end else begin
        x_d   = x_q[k];
        res_d = res_q[k] >> 1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_r <= 1'b0;
      end else if (en_i) begin
        v_r <= v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_r   <= x_d;
        res_r <= res_d;
        sb_r  <= sb_q[k];
      end
    end
    always_comb begin
      v_q[k+1]   = v_r;
      x_q[k+1]   = x_r;
      res_q[k+1] = res_r;
      sb_q[k+1]  = sb_r;
    end
  end

  assign valid_o = v_q[N];
  assign root_o  = res_q[N][N-1:0];
  assign sb_o    = sb_q[N];

endmodule

@@ hdl/ray_sphere_far_clip.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_far_clip
// Far intersection of a ray with a sphere of programmable radius.
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// in       input      in_valid_i/in_stall_o  ray_t
// out      output     out_valid_o/out_stall_i res_t
// cfg      input      APB                  sphere_radius at 0x0
//
// One ray per cycle while the output is not stalled; eight datapath stages plus a
// 24-stage square root.
// The whole pipeline holds while the output is stalled with a valid result.
// in_stall_o is out_stall_i gated by out_valid_o; no transfer is lost or repeated.
// Reset clears valid bits and the radius.
// ----------------------------------------------------------------------------
module ray_sphere_far_clip #(
  parameter int unsigned DIR_FRAC_BITS = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rsfc_pkg::ray_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rsfc_pkg::res_t       out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned CW = rsfc_pkg::CoordW;
  localparam int unsigned VW = CW + 1;
  localparam int unsigned DW = rsfc_pkg::DirW;
  localparam int unsigned RW = rsfc_pkg::RadiusW;
  localparam int unsigned PW = VW + DW;
  localparam int unsigned SW = VW * 2;
  localparam int unsigned DOTW = PW + 2;
  localparam int unsigned TW = DOTW - DIR_FRAC_BITS;
  localparam int unsigned QW = 2 * RW;
  localparam int unsigned SBW = 3 * CW + 3 * DW + TW + 1;
  localparam int unsigned STW = TW + 1;
  localparam int unsigned MW = STW + DW;
  localparam logic signed [MW+1:0] CMax = (MW+2)'((65'sd1 <<< (CW-1)) - 1);
  localparam logic signed [MW+1:0] CMin = -(MW+2)'(65'sd1 <<< (CW-1));

  logic en;
  logic [RW-1:0] radius_q;

  assign pready = 1'b1;
  assign prdata = 32'(radius_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
    end else if (psel && penable && pwrite &&
                 paddr[2 +: rsfc_pkg::AddrW] == rsfc_pkg::RegRadius && paddr[1:0] == 2'b00) begin
      radius_q <= pwdata[RW-1:0];
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: V = C - O
  logic v1_q;
  logic signed [VW-1:0] vx1_q, vy1_q, vz1_q;
  rsfc_pkg::ray_t r1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q  <= in_data_i;
      vx1_q <= VW'(in_data_i.center_x) - VW'(in_data_i.origin_x);
      vy1_q <= VW'(in_data_i.center_y) - VW'(in_data_i.origin_y);
      vz1_q <= VW'(in_data_i.center_z) - VW'(in_data_i.origin_z);
    end
  end

  // stage 2: products
  logic v2_q;
  rsfc_pkg::ray_t r2_q;
  logic signed [PW-1:0] px2_q, py2_q, pz2_q;
  logic [SW-1:0] sx2_q, sy2_q, sz2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q  <= r1_q;
      px2_q <= PW'(vx1_q) * PW'(r1_q.dir_x);
      py2_q <= PW'(vy1_q) * PW'(r1_q.dir_y);
      pz2_q <= PW'(vz1_q) * PW'(r1_q.dir_z);
      sx2_q <= SW'(vx1_q) * SW'(vx1_q);
      sy2_q <= SW'(vy1_q) * SW'(vy1_q);
      sz2_q <= SW'(vz1_q) * SW'(vz1_q);
    end
  end

  // stage 3: sums
  logic v3_q;
  rsfc_pkg::ray_t r3_q;
  logic signed [DOTW-1:0] dot3_q;
  logic [SW+1:0] vsq3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r3_q   <= r2_q;
      dot3_q <= DOTW'(px2_q) + DOTW'(py2_q) + DOTW'(pz2_q);
      vsq3_q <= (SW+2)'(sx2_q) + (SW+2)'(sy2_q) + (SW+2)'(sz2_q);
    end
  end

  // stage 4: t and t^2, R^2
  logic v4_q, ahead4_q;
  rsfc_pkg::ray_t r4_q;
  logic [TW-1:0] t4_q;
  logic [2*TW-1:0] tsq4_q;
  logic [SW+1:0] vsq4_q;
  logic [QW-1:0] r2_4_q;
  logic [TW-1:0] t_d;
  assign t_d = TW'(dot3_q >>> DIR_FRAC_BITS);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r4_q     <= r3_q;
      ahead4_q <= !dot3_q[DOTW-1];
      t4_q     <= t_d;
      tsq4_q   <= (2*TW)'(t_d) * (2*TW)'(t_d);
      vsq4_q   <= vsq3_q;
      r2_4_q   <= QW'(radius_q) * QW'(radius_q);
    end
  end

  // stage 5: d2 and hit test
  localparam int unsigned WW = (2*TW > SW+2) ? 2*TW : SW+2;
  logic v5_q, hit5_q;
  rsfc_pkg::ray_t r5_q;
  logic [TW-1:0] t5_q;
  logic [QW-1:0] rad5_q;
  logic [WW-1:0] d2_w;
  always_comb begin
    if (WW'(vsq4_q) >= WW'(tsq4_q)) d2_w = WW'(vsq4_q) - WW'(tsq4_q);
    else d2_w = '0;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      r5_q   <= r4_q;
      t5_q   <= t4_q;
      hit5_q <= ahead4_q && (WW'(r2_4_q) >= d2_w);
      rad5_q <= r2_4_q - d2_w[QW-1:0];
    end
  end

  // square root
  logic sv;
  logic [SBW-1:0] sb_in, sb_out;
  logic [RW-1:0] root;
  assign sb_in = {r5_q.origin_x, r5_q.origin_y, r5_q.origin_z,
                  r5_q.dir_x, r5_q.dir_y, r5_q.dir_z, t5_q, hit5_q};
  rsfc_sqrt #(.InW(QW), .SbW(SBW)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .rad_i(rad5_q), .sb_i(sb_in),
    .valid_o(sv), .root_o(root), .sb_o(sb_out)
  );

  logic signed [CW-1:0] ox6, oy6, oz6;
  logic signed [DW-1:0] dx6, dy6, dz6;
  logic [TW-1:0] t6;
  logic h6;
  assign {ox6, oy6, oz6, dx6, dy6, dz6, t6, h6} = sb_out;

  // stage 6: s
  logic v6_q, h6_q;
  logic [STW-1:0] s6_q;
  logic signed [CW-1:0] ox6_q, oy6_q, oz6_q;
  logic signed [DW-1:0] dx6_q, dy6_q, dz6_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= sv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h6_q <= h6;
      s6_q <= STW'(t6) + STW'(root);
      ox6_q <= ox6; oy6_q <= oy6; oz6_q <= oz6;
      dx6_q <= dx6; dy6_q <= dy6; dz6_q <= dz6;
    end
  end

  // stage 7: |s*d|
  logic v7_q, h7_q;
  logic [MW-1:0] mx7_q, my7_q, mz7_q;
  logic nx7_q, ny7_q, nz7_q;
  logic signed [CW-1:0] ox7_q, oy7_q, oz7_q;
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] a);
    mag = a[DW-1] ? DW'(-a) : a;
  endfunction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h7_q <= h6_q;
      mx7_q <= MW'(s6_q) * MW'(mag(dx6_q));
      my7_q <= MW'(s6_q) * MW'(mag(dy6_q));
      mz7_q <= MW'(s6_q) * MW'(mag(dz6_q));
      nx7_q <= dx6_q[DW-1]; ny7_q <= dy6_q[DW-1]; nz7_q <= dz6_q[DW-1];
      ox7_q <= ox6_q; oy7_q <= oy6_q; oz7_q <= oz6_q;
    end
  end

  // stage 8: step, add, saturate
  function automatic logic signed [CW-1:0] adv(input logic signed [CW-1:0] o,
                                               input logic [MW-1:0] m, input logic n);
    logic signed [MW:0] st;
    logic signed [MW+1:0] p;
    st = $signed({1'b0, m >> DIR_FRAC_BITS});
    if (n) st = -st;
    p = (MW+2)'(o) + (MW+2)'(st);
    if (p > CMax) p = CMax;
    if (p < CMin) p = CMin;
    adv = CW'(p);
  endfunction

  logic v8_q;
  rsfc_pkg::res_t res8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res8_q.hit     <= h7_q;
      res8_q.point_x <= h7_q ? adv(ox7_q, mx7_q, nx7_q) : '0;
      res8_q.point_y <= h7_q ? adv(oy7_q, my7_q, ny7_q) : '0;
      res8_q.point_z <= h7_q ? adv(oz7_q, mz7_q, nz7_q) : '0;
    end
  end

  assign out_valid_o = v8_q;
  assign out_data_o  = res8_q;

endmodule

@@ hdl/rsfc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfc_checker
// Port-level checks for the ray/sphere far clip block.
// ----------------------------------------------------------------------------
module rsfc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rsfc_pkg::res_t out_data_o
);

  a_stall_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i)) else $error("stall mismatch");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      out_data_o.point_x == '0 && out_data_o.point_y == '0 && out_data_o.point_z == '0)
    else $error("miss with nonzero point");

endmodule

bind ray_sphere_far_clip rsfc_checker u_rsfc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ray/sphere far clip block against a built-in far-point predictor:
// directed corner rays, random hits and misses over several radii, random
// gaps on both sides and a long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned DirFrac   = 14;
  localparam int unsigned LatCycles = 60;
  localparam longint      CycleLimit = 400000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  rsfc_pkg::ray_t in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  rsfc_pkg::res_t out_data_o;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  rsfc_pkg::res_t far_points_q[$];
  logic [23:0] radius_q;
  int          errors = 0;
  int          hits_seen = 0;
  int          results_seen = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;

  ray_sphere_far_clip u_top (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("[ray_sphere_far_clip] ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] advance_coord(longint o, logic [63:0] s,
                                                      longint d);
    logic [127:0] m;
    logic [127:0] q;
    longint       step;
    longint       p;
    m = s * 128'(d < 0 ? -d : d);
    q = m >> DirFrac;
    step = (q > 128'(64'd1 << 62)) ? (64'sd1 <<< 62) : longint'(q[63:0]);
    if (d < 0) step = -step;
    p = o + step;
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic rsfc_pkg::res_t predict_far_point(rsfc_pkg::ray_t ray);
    longint      o[3], d[3], v[3];
    logic signed [127:0] dot;
    logic [127:0] vsq, tsq, d2, r2;
    logic [63:0] t, s;
    rsfc_pkg::res_t res;
    o = '{ray.origin_x, ray.origin_y, ray.origin_z};
    d = '{ray.dir_x, ray.dir_y, ray.dir_z};
    v = '{longint'(ray.center_x) - o[0], longint'(ray.center_y) - o[1],
          longint'(ray.center_z) - o[2]};
    dot = 0;
    vsq = 0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      dot += 128'(v[i]) * 128'(d[i]);
      vsq += 128'(v[i]) * 128'(v[i]);
    end
    if (dot < 0) return res;
    t = 64'(dot >>> DirFrac);
    tsq = 128'(t) * 128'(t);
    d2 = (vsq >= tsq) ? vsq - tsq : 128'd0;
    r2 = 128'(radius_q) * 128'(radius_q);
    if (d2 > r2) return res;
    s = t + floor_sqrt(64'(r2 - d2));
    res.hit = 1'b1;
    res.point_x = advance_coord(o[0], s, d[0]);
    res.point_y = advance_coord(o[1], s, d[1]);
    res.point_z = advance_coord(o[2], s, d[2]);
    return res;
  endfunction

  task automatic write_radius(logic [23:0] r);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {rsfc_pkg::RegRadius, 2'b00};
    pwdata <= 32'(r);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    radius_q = r;
  endtask

  task automatic send_ray(rsfc_pkg::ray_t ray, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ray;
    far_points_q.push_back(predict_far_point(ray));
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (far_points_q.size() != 0) @(posedge clk_i);
    repeat (LatCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (far_points_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        rsfc_pkg::res_t exp_res;
        exp_res = far_points_q.pop_front();
        if (out_data_o.hit) hits_seen++;
        if (out_data_o.hit !== exp_res.hit)
          $display("%0t hit exp %0b got %0b", $time, exp_res.hit, out_data_o.hit);
        if (out_data_o.point_x !== exp_res.point_x)
          $display("%0t point_x exp %0d got %0d", $time, exp_res.point_x,
                   out_data_o.point_x);
        if (out_data_o.point_y !== exp_res.point_y)
          $display("%0t point_y exp %0d got %0d", $time, exp_res.point_y,
                   out_data_o.point_y);
        if (out_data_o.point_z !== exp_res.point_z)
          $display("%0t point_z exp %0d got %0d", $time, exp_res.point_z,
                   out_data_o.point_z);
        if (out_data_o !== exp_res) errors++;
      end
    end
  end

  int stall_wait = 0;
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if (stall_wait > 0) begin
      stall_wait <= stall_wait - 1;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      stall_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [15:0] unit_dir();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord(int span);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Ray aimed near the centre so that most rays hit.
  function automatic rsfc_pkg::ray_t aimed_ray(int span);
    rsfc_pkg::ray_t r;
    r.origin_x = rand_coord(span); r.origin_y = rand_coord(span);
    r.origin_z = rand_coord(span);
    r.dir_x = unit_dir(); r.dir_y = unit_dir(); r.dir_z = unit_dir();
    r.center_x = r.origin_x + ((r.dir_x * 32'sd40) >>> 4) + $signed($urandom_range(0, 64)) - 32;
    r.center_y = r.origin_y + ((r.dir_y * 32'sd40) >>> 4) + $signed($urandom_range(0, 64)) - 32;
    r.center_z = r.origin_z + ((r.dir_z * 32'sd40) >>> 4) + $signed($urandom_range(0, 64)) - 32;
    return r;
  endfunction

  function automatic rsfc_pkg::ray_t noise_ray();
    rsfc_pkg::ray_t r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         16'($urandom)};
    return r;
  endfunction

  task automatic test_directed();
    rsfc_pkg::ray_t r;
    write_radius(24'd0);
    r = '0; r.dir_x = 16'sd16384; r.center_x = 32'sd160;
    send_ray(r, 0);
    r.center_y = 32'sd1; send_ray(r, 0);
    r.center_x = -32'sd160; r.center_y = 0; send_ray(r, 0);
    drain();
    write_radius(24'hFFFFFF);
    r = '0; r.dir_x = 16'sd16384; send_ray(r, 0);
    r.center_y = 32'sd160; send_ray(r, 0);
    r = '0; r.dir_x = 16'h8000; r.center_x = 32'h8000_0000; send_ray(r, 0);
    r = '0; r.origin_x = 32'h7FFF_FFFF; r.dir_x = 16'sd16384; r.center_x = 32'h7FFF_FFFF;
    send_ray(r, 0);
    r = '0; r.origin_z = 32'h8000_0000; r.dir_z = -16'sd16384;
    r.center_z = 32'h8000_0000; send_ray(r, 0);
    r = '0; r.dir_x = 16'h7FFF; r.dir_y = 16'h7FFF; r.dir_z = 16'h7FFF;
    r.center_y = 32'sd1000; send_ray(r, 0);
    r = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h8000,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_ray(r, 0);
    r = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    send_ray(r, 0);
    drain();
  endtask

  task automatic test_random_radius(logic [23:0] r, int n);
    write_radius(r);
    repeat (n) send_ray(($urandom_range(0, 4) == 0) ? noise_ray() : aimed_ray(4000), 1);
    drain();
  endtask

  task automatic test_backpressure();
    write_radius(24'd800);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (120) send_ray(aimed_ray(2000), 0);
    join
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    radius_q = '0;
    test_directed();
    test_random_radius(24'd1, 100);
    test_random_radius(24'd640, 200);
    test_random_radius(24'($urandom_range(0, 24'hFFFFFF)), 130);
    test_random_radius(24'hFFFFFF, 100);
    test_backpressure();
    if (far_points_q.size() != 0) errors++;
    $display("covered %0d results, %0d hits, radii from zero to full scale,",
             results_seen, hits_seen);
    $display("random gaps both sides and a long output hold-off");
    if (errors == 0) begin
      $display("[ray_sphere_far_clip] OK");
    end else begin
      $display("[ray_sphere_far_clip] ERROR");
    end
    $finish;
  end

endmodule

@@ ray_sphere_far_clip.f @@
hdl/rsfc_pkg.sv
hdl/rsfc_sqrt.sv
hdl/ray_sphere_far_clip.sv
hdl/rsfc_checker.sv
tb/sv/testbench.sv
